FILE: hw/rtl/repd_pkg.sv
// Shared types and constants of the rotary encoder and press decoder.
`default_nettype none

package repd_pkg;

   // Codes of the input event type field
   typedef enum logic [1:0] {
      REQ_CONTACT_A = 2'd0,
      REQ_CONTACT_B = 2'd1,
      REQ_SWITCH    = 2'd2,
      REQ_TICK      = 2'd3
   } req_code_type;

   // Classified item kinds between the front and the back
   typedef enum logic [1:0] {
      ITEM_ROTATE = 2'd0,
      ITEM_SWITCH = 2'd1,
      ITEM_TICK   = 2'd2
   } item_kind_type;

   // Press tracking phases
   typedef enum logic [1:0] {
      PHASE_IDLE    = 2'd0,
      PHASE_COUNT   = 2'd1,
      PHASE_RELEASE = 2'd2
   } phase_type;

   // Result event kinds
   localparam logic [1:0] EVT_ANTICLOCKWISE = 2'd0;
   localparam logic [1:0] EVT_CLOCKWISE     = 2'd1;
   localparam logic [1:0] EVT_SHORT_PRESS   = 2'd2;
   localparam logic [1:0] EVT_LONG_PRESS    = 2'd3;

   // Configuration register indexes
   localparam logic [2:0] CSR_EDGE_GAP_US       = 3'd0;
   localparam logic [2:0] CSR_STEPS_PER_REPORT  = 3'd1;
   localparam logic [2:0] CSR_DEBOUNCE_MS       = 3'd2;
   localparam logic [2:0] CSR_REPEAT_MS         = 3'd3;
   localparam logic [2:0] CSR_LONG_CHECKS       = 3'd4;
   localparam logic [2:0] CSR_PRESS_TAG         = 3'd5;
   localparam logic [2:0] CSR_ANTICLOCKWISE_TAG = 3'd6;
   localparam logic [2:0] CSR_CLOCKWISE_TAG     = 3'd7;

   // Configuration reset values
   localparam logic [19:0] RST_EDGE_GAP_US       = 20'd1000;
   localparam logic [7:0]  RST_STEPS_PER_REPORT  = 8'd4;
   localparam logic [15:0] RST_DEBOUNCE_MS       = 16'd150;
   localparam logic [15:0] RST_REPEAT_MS         = 16'd250;
   localparam logic [7:0]  RST_LONG_CHECKS       = 8'd4;
   localparam logic [7:0]  RST_PRESS_TAG         = 8'd0;
   localparam logic [7:0]  RST_ANTICLOCKWISE_TAG = 8'd1;
   localparam logic [7:0]  RST_CLOCKWISE_TAG     = 8'd2;

   localparam int TimeWidth = 48;

   // Classified item held in the queue
   typedef struct packed {
      item_kind_type          kind;
      logic                   anti;
      logic [TimeWidth-1:0]   now_us;
      logic                   sw;
   } item_type;

   // Queue push side
   typedef struct packed {
      logic     valid;
      item_type item;
   } push_type;

   // Configuration register set
   typedef struct packed {
      logic [19:0] edge_gap_us;
      logic [7:0]  steps_per_report;
      logic [15:0] debounce_ms;
      logic [15:0] repeat_ms;
      logic [7:0]  long_checks;
      logic [7:0]  press_tag;
      logic [7:0]  anticlockwise_tag;
      logic [7:0]  clockwise_tag;
   } cfg_type;

endpackage

`default_nettype wire

FILE: hw/rtl/rotary_encoder_press_decoder_top.sv
// Top level of the rotary encoder and press decoder.
//
// Input channel (req_*): one event per item: contact A or B fall with a
// microsecond timestamp and contact levels, switch fall, or millisecond tick.
// Result channel (rsp_*): rotation reports on the encoder channel, short and
// long presses (long press flagged by rsp_to_gui).
// Configuration (csr_*): one register written per cycle with csr_write_enable;
// write only while no item is in flight.
// The front end classifies each item into a two-entry queue; the back end
// pops one item per cycle while no untaken result blocks it, and updates
// counters and press state as it pops the item. A result is presented the
// cycle after its item leaves the queue; one item is accepted every cycle
// while the result register drains.
// When the receiver stalls, the result register holds; the back end stops
// popping while an untaken result sits in it, and the input stops once the
// queue is full, two items later.
// Reset (synchronous, active high) clears counts, press state, the queue and
// the result register, and restores the configuration defaults.
`default_nettype none

module rotary_encoder_press_decoder_top (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [1:0]   req_type,
   input  wire logic [47:0]  req_now_us,
   input  wire logic         req_level_a,
   input  wire logic         req_level_b,
   input  wire logic         req_switch_pressed,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [1:0]        rsp_event_kind,
   output logic [7:0]        rsp_event_tag,
   output logic              rsp_to_gui,
   input  wire logic         csr_write_enable,
   input  wire logic [2:0]   csr_index,
   input  wire logic [19:0]  csr_wdata
);
   import repd_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   push_type  push;
   logic      queue_full;
   logic      q_valid;
   item_type  q_item;
   logic      q_pop;

   // Write configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_EDGE_GAP_US:       cfg_in.edge_gap_us       = csr_wdata;
            CSR_STEPS_PER_REPORT:  cfg_in.steps_per_report  = csr_wdata[7:0];
            CSR_DEBOUNCE_MS:       cfg_in.debounce_ms       = csr_wdata[15:0];
            CSR_REPEAT_MS:         cfg_in.repeat_ms         = csr_wdata[15:0];
            CSR_LONG_CHECKS:       cfg_in.long_checks       = csr_wdata[7:0];
            CSR_PRESS_TAG:         cfg_in.press_tag         = csr_wdata[7:0];
            CSR_ANTICLOCKWISE_TAG: cfg_in.anticlockwise_tag = csr_wdata[7:0];
            CSR_CLOCKWISE_TAG:     cfg_in.clockwise_tag     = csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.edge_gap_us       <= RST_EDGE_GAP_US;
         cfg_ff.steps_per_report  <= RST_STEPS_PER_REPORT;
         cfg_ff.debounce_ms       <= RST_DEBOUNCE_MS;
         cfg_ff.repeat_ms         <= RST_REPEAT_MS;
         cfg_ff.long_checks       <= RST_LONG_CHECKS;
         cfg_ff.press_tag         <= RST_PRESS_TAG;
         cfg_ff.anticlockwise_tag <= RST_ANTICLOCKWISE_TAG;
         cfg_ff.clockwise_tag     <= RST_CLOCKWISE_TAG;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   repd_front u_front (
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_now_us         (req_now_us),
      .req_level_a        (req_level_a),
      .req_level_b        (req_level_b),
      .req_switch_pressed (req_switch_pressed),
      .queue_full         (queue_full),
      .push               (push)
   );

   repd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (queue_full),
      .pop_valid (q_valid),
      .pop_item  (q_item),
      .pop       (q_pop)
   );

   repd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .item_valid     (q_valid),
      .item           (q_item),
      .item_pop       (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_kind (rsp_event_kind),
      .rsp_event_tag  (rsp_event_tag),
      .rsp_to_gui     (rsp_to_gui)
   );

endmodule

`default_nettype wire

FILE: hw/rtl/repd_front.sv
// Front end: accepts input items and classifies them for the back end.
`default_nettype none

module repd_front (
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [1:0]                req_type,
   input  wire logic [47:0]               req_now_us,
   input  wire logic                      req_level_a,
   input  wire logic                      req_level_b,
   input  wire logic                      req_switch_pressed,
   input  wire logic                      queue_full,
   output repd_pkg::push_type             push
);
   import repd_pkg::*;

   req_code_type code;

   assign code      = req_code_type'(req_type);
   assign req_ready = !queue_full;

   // Classify the event and derive the rotation direction
   always_comb begin
      push.valid       = req_valid && !queue_full;
      push.item.now_us = req_now_us;
      push.item.sw     = req_switch_pressed;
      push.item.anti   = (code == REQ_CONTACT_A) ? (req_level_a == req_level_b)
                                                 : (req_level_a != req_level_b);
      case (code)
         REQ_CONTACT_A: push.item.kind = ITEM_ROTATE;
         REQ_CONTACT_B: push.item.kind = ITEM_ROTATE;
         REQ_SWITCH:    push.item.kind = ITEM_SWITCH;
         REQ_TICK:      push.item.kind = ITEM_TICK;
         default:       push.item.kind = ITEM_TICK;
      endcase
   end

endmodule

`default_nettype wire

FILE: hw/rtl/repd_queue.sv
// Two-entry queue of classified items between the front and back ends.
`default_nettype none

module repd_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire repd_pkg::push_type  push,
   output logic                     full,
   output logic                     pop_valid,
   output repd_pkg::item_type       pop_item,
   input  wire logic                pop
);
   import repd_pkg::*;

   item_type    entries_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_item  = entries_ff[rd_ptr_ff];
   assign do_push   = push.valid && !full;
   assign do_pop    = pop && pop_valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.item;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/repd_back.sv
// Back end: rotation counting, press tracking and the result register.
`default_nettype none

module repd_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire repd_pkg::cfg_type   cfg,
   input  wire logic                item_valid,
   input  wire repd_pkg::item_type  item,
   output logic                     item_pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [1:0]               rsp_event_kind,
   output logic [7:0]               rsp_event_tag,
   output logic                     rsp_to_gui
);
   import repd_pkg::*;

   logic [TimeWidth-1:0] last_edge_ff, last_edge_in;
   logic [7:0]           anti_cnt_ff, anti_cnt_in;
   logic [7:0]           cw_cnt_ff, cw_cnt_in;
   phase_type            phase_ff, phase_in;
   logic [15:0]          countdown_ff, countdown_in;
   logic [7:0]           held_ff, held_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           kind_ff, kind_in;
   logic [7:0]           tag_ff, tag_in;
   logic                 gui_ff, gui_in;

   logic                 take;
   logic                 emit;
   logic [1:0]           emit_kind;
   logic [7:0]           emit_tag;
   logic                 emit_gui;
   logic [TimeWidth:0]   gap_limit;
   logic                 gap_ok;
   logic [7:0]           anti_inc, cw_inc;

   assign take     = item_valid && (!rsp_valid_ff || rsp_ready);
   assign item_pop = take;

   assign gap_limit = {1'b0, last_edge_ff} + {{(TimeWidth - 19){1'b0}}, cfg.edge_gap_us};
   assign gap_ok    = {1'b0, item.now_us} > gap_limit;
   assign anti_inc  = (anti_cnt_ff == 8'hFF) ? anti_cnt_ff : anti_cnt_ff + 8'd1;
   assign cw_inc    = (cw_cnt_ff == 8'hFF) ? cw_cnt_ff : cw_cnt_ff + 8'd1;

   // Update decoder state for the item at the head of the queue
   always_comb begin
      last_edge_in = last_edge_ff;
      anti_cnt_in  = anti_cnt_ff;
      cw_cnt_in    = cw_cnt_ff;
      phase_in     = phase_ff;
      countdown_in = countdown_ff;
      held_in      = held_ff;
      emit         = 1'b0;
      emit_kind    = EVT_ANTICLOCKWISE;
      emit_tag     = cfg.anticlockwise_tag;
      emit_gui     = 1'b0;
      if (take) begin
         case (item.kind)
            ITEM_ROTATE: begin
               if (gap_ok) begin
                  last_edge_in = item.now_us;
                  if (item.anti) begin
                     anti_cnt_in = anti_inc;
                     if (anti_inc >= cfg.steps_per_report) begin
                        anti_cnt_in = 8'd0;
                        cw_cnt_in   = 8'd0;
                        emit        = 1'b1;
                     end
                  end else begin
                     cw_cnt_in = cw_inc;
                     if (cw_inc >= cfg.steps_per_report) begin
                        anti_cnt_in = 8'd0;
                        cw_cnt_in   = 8'd0;
                        emit        = 1'b1;
                        emit_kind   = EVT_CLOCKWISE;
                        emit_tag    = cfg.clockwise_tag;
                     end
                  end
               end
            end
            ITEM_SWITCH: begin
               if (phase_ff != PHASE_COUNT && phase_ff != PHASE_RELEASE) begin
                  phase_in     = PHASE_COUNT;
                  countdown_in = cfg.debounce_ms;
                  held_in      = 8'd0;
               end
            end
            ITEM_TICK: begin
               if (phase_ff == PHASE_COUNT) begin
                  if (countdown_ff > 16'd1) begin
                     countdown_in = countdown_ff - 16'd1;
                  end else if (!item.sw) begin
                     countdown_in = 16'd0;
                     phase_in     = PHASE_IDLE;
                     held_in      = 8'd0;
                     emit         = 1'b1;
                     emit_kind    = EVT_SHORT_PRESS;
                     emit_tag     = cfg.press_tag;
                  end else if (held_ff >= cfg.long_checks) begin
                     countdown_in = 16'd0;
                     phase_in     = PHASE_RELEASE;
                     held_in      = 8'd0;
                  end else begin
                     held_in      = (held_ff == 8'hFF) ? held_ff : held_ff + 8'd1;
                     countdown_in = cfg.repeat_ms;
                  end
               end else if (phase_ff == PHASE_RELEASE) begin
                  if (!item.sw) begin
                     phase_in  = PHASE_IDLE;
                     emit      = 1'b1;
                     emit_kind = EVT_LONG_PRESS;
                     emit_tag  = cfg.press_tag;
                     emit_gui  = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Load the result register, or drop its item once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      kind_in      = kind_ff;
      tag_in       = tag_ff;
      gui_in       = gui_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
         kind_in      = emit_kind;
         tag_in       = emit_tag;
         gui_in       = emit_gui;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_edge_ff <= '0;
         anti_cnt_ff  <= 8'd0;
         cw_cnt_ff    <= 8'd0;
         phase_ff     <= PHASE_IDLE;
         countdown_ff <= 16'd0;
         held_ff      <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         last_edge_ff <= last_edge_in;
         anti_cnt_ff  <= anti_cnt_in;
         cw_cnt_ff    <= cw_cnt_in;
         phase_ff     <= phase_in;
         countdown_ff <= countdown_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      tag_ff  <= tag_in;
      gui_ff  <= gui_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_kind = kind_ff;
   assign rsp_event_tag  = tag_ff;
   assign rsp_to_gui     = gui_ff;

endmodule

`default_nettype wire
